/* hdl/bltk_pkg.sv */
`timescale 1ns / 1ps

package bltk_pkg;

  // Internal position counter widths; positions saturate at all ones.
  localparam int LINE_WIDTH   = 16;
  localparam int COLUMN_WIDTH = 16;

  // Port widths of the result fields.
  localparam int LINE_OUT_W = 16;
  localparam int COL_OUT_W  = 16;
  localparam int KIND_W     = 4;
  localparam int CODE_W     = 2;
  localparam int MAX_RES    = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Result kinds
  localparam logic [KIND_W-1:0] K_LBRACK  = 4'd0;
  localparam logic [KIND_W-1:0] K_RBRACK  = 4'd1;
  localparam logic [KIND_W-1:0] K_LBRACE  = 4'd2;
  localparam logic [KIND_W-1:0] K_RBRACE  = 4'd3;
  localparam logic [KIND_W-1:0] K_LPAREN  = 4'd4;
  localparam logic [KIND_W-1:0] K_RPAREN  = 4'd5;
  localparam logic [KIND_W-1:0] K_SEMI    = 4'd6;
  localparam logic [KIND_W-1:0] K_IDCHAR  = 4'd7;
  localparam logic [KIND_W-1:0] K_IDEND   = 4'd8;
  localparam logic [KIND_W-1:0] K_STRCHAR = 4'd9;
  localparam logic [KIND_W-1:0] K_STREND  = 4'd10;
  localparam logic [KIND_W-1:0] K_EOF     = 4'd11;
  localparam logic [KIND_W-1:0] K_ERROR   = 4'd12;

  // Error codes
  localparam logic [CODE_W-1:0] ERR_NONPRINT    = 2'd0;
  localparam logic [CODE_W-1:0] ERR_END_QUOTE   = 2'd1;
  localparam logic [CODE_W-1:0] ERR_END_STRING  = 2'd2;

  // One classified item: up to three results sharing before/after positions.
  typedef struct packed {
    logic [1:0]                    cnt;
    logic [MAX_RES-1:0][KIND_W-1:0] kinds;
    logic [7:0]                    ch;
    logic [CODE_W-1:0]             code;
    logic [LINE_WIDTH-1:0]         line_b;
    logic [COLUMN_WIDTH-1:0]       col_b;
    logic [LINE_WIDTH-1:0]         line_a;
    logic [COLUMN_WIDTH-1:0]       col_a;
  } pkt_t;

endpackage

/* hdl/bracket_language_tokenizer.sv */
`timescale 1ns / 1ps

// Streaming tokenizer for a small bracket language.
// Input channel: one beat is a source byte, or an end mark when end_of_input
// is set; accepted when in_valid is high and in_stall low.
// Output channel: one beat per result (kind, char_value, line_number,
// column_number, error_code, last); taken when out_valid is high and
// out_stall low. last marks the final result caused by one input beat.
// Path: an accepted input beat is written into the queue, and each of its
// results then passes through the output register.
// Throughput: one input beat per cycle while the queue has room; a beat with
// two or three results emits one result per output beat, and the four-entry
// queue between classifier and emitter absorbs it, so input stalls only once
// it fills. Whitespace, comments and opening quotes alone push no result.
// Reset: synchronous; mode returns to between tokens, line 1, column 0, and
// the queue and output register empty.
// A receiver stall holds the output register; input keeps flowing until the
// queue is full. A non-printable byte that starts a token reports an error
// and the block then drops every input beat until reset.
module bracket_language_tokenizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       source_byte,
  input  logic                             end_of_input,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic [bltk_pkg::KIND_W-1:0]      kind,
  output logic [7:0]                       char_value,
  output logic [bltk_pkg::LINE_OUT_W-1:0]  line_number,
  output logic [bltk_pkg::COL_OUT_W-1:0]   column_number,
  output logic [bltk_pkg::CODE_W-1:0]      error_code,
  output logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall
);
  import bltk_pkg::*;

  logic push, pop, full, empty;
  pkt_t push_pkt, head;

  bltk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .source_byte  (source_byte),
    .end_of_input (end_of_input),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .queue_full   (full),
    .push         (push),
    .push_pkt     (push_pkt)
  );

  bltk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  bltk_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .kind          (kind),
    .char_value    (char_value),
    .line_number   (line_number),
    .column_number (column_number),
    .error_code    (error_code),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule

/* hdl/bltk_front.sv */
`timescale 1ns / 1ps

module bltk_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        source_byte,
  input  logic              end_of_input,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              queue_full,
  output logic              push,
  output bltk_pkg::pkt_t    push_pkt
);
  import bltk_pkg::*;

  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_STRING  = 3'd2;
  localparam logic [2:0] M_ESCAPE  = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  logic [2:0]              mode, mode_next;
  logic [LINE_WIDTH-1:0]   line, line_adv;
  logic [COLUMN_WIDTH-1:0] col, col_adv;
  logic                    shb, shb_next;
  logic                    halted, halted_next;
  logic                    adv;
  logic                    accept;
  pkt_t                    pkt;

  // between-tokens handling of the current byte
  logic              bw_adv, bw_emit, bw_shb, bw_halt;
  logic [KIND_W-1:0] bw_kind;
  logic [7:0]        bw_ch;
  logic [2:0]        bw_mode;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_LBRACE) ||
           (b == CH_RBRACE) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_SEMI);
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_SEMI;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] b);
    logic [7:0] d;
    unique case (b)
      8'h61:   d = 8'd7;   // a
      8'h62:   d = 8'd8;   // b
      8'h66:   d = 8'd12;  // f
      8'h6E:   d = 8'd10;  // n
      8'h72:   d = 8'd13;  // r
      8'h74:   d = 8'd9;   // t
      8'h76:   d = 8'd11;  // v
      default: d = b;
    endcase
    return d;
  endfunction

  assign accept   = in_valid && !queue_full;
  assign in_stall = queue_full;

  always_comb begin
    // saturating position advance
    if (source_byte == CH_NEWLINE) begin
      line_adv = (line != '1) ? line + 1'b1 : line;
      col_adv  = '0;
    end else begin
      line_adv = line;
      col_adv  = (col != '1) ? col + 1'b1 : col;
    end

    bw_adv  = 1'b0;
    bw_emit = 1'b0;
    bw_kind = K_IDCHAR;
    bw_ch   = 8'd0;
    bw_mode = M_BETWEEN;
    bw_shb  = shb;
    bw_halt = 1'b0;
    if (is_space(source_byte)) begin
      bw_adv = 1'b1;
    end else if (source_byte < 8'd32 || source_byte >= 8'd127) begin
      bw_emit = 1'b1;
      bw_kind = K_ERROR;
      bw_halt = 1'b1;
    end else if (source_byte == CH_QUOTE) begin
      bw_adv  = 1'b1;
      bw_mode = M_STRING;
      bw_shb  = 1'b0;
    end else if (source_byte == CH_HASH) begin
      bw_adv  = 1'b1;
      bw_mode = M_COMMENT;
    end else if (is_punct(source_byte)) begin
      bw_adv  = 1'b1;
      bw_emit = 1'b1;
      bw_kind = punct_kind(source_byte);
    end else begin
      bw_adv  = 1'b1;
      bw_emit = 1'b1;
      bw_ch   = source_byte;
      bw_mode = M_IDENT;
    end

    pkt         = '0;
    adv         = 1'b0;
    mode_next   = mode;
    shb_next    = shb;
    halted_next = halted;

    if (!end_of_input) begin
      unique case (mode)
        M_IDENT: begin
          if (is_space(source_byte) || is_punct(source_byte) ||
              source_byte == CH_QUOTE || source_byte == CH_HASH) begin
            // close the identifier, then lex the byte as a fresh token
            pkt.kinds[0] = K_IDEND;
            pkt.kinds[1] = bw_kind;
            pkt.cnt      = bw_emit ? 2'd2 : 2'd1;
            adv          = bw_adv;
            mode_next    = bw_mode;
            shb_next     = bw_shb;
            halted_next  = bw_halt;
          end else begin
            pkt.kinds[0] = K_IDCHAR;
            pkt.ch       = source_byte;
            pkt.cnt      = 2'd1;
            adv          = 1'b1;
          end
        end
        M_STRING: begin
          adv = 1'b1;
          if (source_byte == CH_QUOTE) begin
            pkt.kinds[0] = K_STREND;
            pkt.cnt      = 2'd1;
            mode_next    = M_BETWEEN;
            shb_next     = 1'b0;
          end else if (source_byte == CH_BSLASH) begin
            mode_next = M_ESCAPE;
            shb_next  = 1'b1;
          end else begin
            pkt.kinds[0] = K_STRCHAR;
            pkt.ch       = source_byte;
            pkt.cnt      = 2'd1;
            shb_next     = 1'b1;
          end
        end
        M_ESCAPE: begin
          pkt.kinds[0] = K_STRCHAR;
          pkt.ch       = decode_escape(source_byte);
          pkt.cnt      = 2'd1;
          adv          = 1'b1;
          mode_next    = M_STRING;
          shb_next     = 1'b1;
        end
        M_COMMENT: begin
          adv = 1'b1;
          if (source_byte == CH_NEWLINE) mode_next = M_BETWEEN;
        end
        default: begin
          pkt.kinds[0] = bw_kind;
          pkt.ch       = bw_ch;
          pkt.code     = ERR_NONPRINT;
          pkt.cnt      = {1'b0, bw_emit};
          adv          = bw_adv;
          mode_next    = bw_mode;
          shb_next     = bw_shb;
          halted_next  = bw_halt;
        end
      endcase
    end else begin
      mode_next = M_BETWEEN;
      shb_next  = 1'b0;
      case (mode) inside
        M_IDENT: begin
          pkt.kinds[0] = K_IDEND;
          pkt.kinds[1] = K_EOF;
          pkt.cnt      = 2'd2;
        end
        M_STRING, M_ESCAPE: begin
          pkt.kinds[0] = K_ERROR;
          if (mode == M_STRING && !shb) begin
            pkt.code     = ERR_END_QUOTE;
            pkt.kinds[1] = K_EOF;
            pkt.cnt      = 2'd2;
          end else begin
            pkt.code     = ERR_END_STRING;
            pkt.kinds[1] = K_STREND;
            pkt.kinds[2] = K_EOF;
            pkt.cnt      = 2'd3;
          end
        end
        default: begin
          pkt.kinds[0] = K_EOF;
          pkt.cnt      = 2'd1;
        end
      endcase
    end

    pkt.line_b = line;
    pkt.col_b  = col;
    pkt.line_a = adv ? line_adv : line;
    pkt.col_a  = adv ? col_adv : col;
  end

  assign push     = accept && !halted && (pkt.cnt != 2'd0);
  assign push_pkt = pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_BETWEEN;
      line   <= LINE_WIDTH'(1);
      col    <= '0;
      shb    <= 1'b0;
      halted <= 1'b0;
    end else if (accept && !halted) begin
      mode   <= mode_next;
      line   <= pkt.line_a;
      col    <= pkt.col_a;
      shb    <= shb_next;
      halted <= halted_next;
    end
  end

endmodule

/* hdl/bltk_queue.sv */
`timescale 1ns / 1ps

module bltk_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bltk_pkg::pkt_t push_pkt,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output bltk_pkg::pkt_t head
);
  import bltk_pkg::*;

  pkt_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_pkt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

/* hdl/bltk_back.sv */
`timescale 1ns / 1ps

module bltk_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             empty,
  input  bltk_pkg::pkt_t                   head,
  output logic                             pop,
  output logic [bltk_pkg::KIND_W-1:0]      kind,
  output logic [7:0]                       char_value,
  output logic [bltk_pkg::LINE_OUT_W-1:0]  line_number,
  output logic [bltk_pkg::COL_OUT_W-1:0]   column_number,
  output logic [bltk_pkg::CODE_W-1:0]      error_code,
  output logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall
);
  import bltk_pkg::*;

  logic [1:0]        idx;
  logic              load;
  logic              last_slot;
  logic [KIND_W-1:0] slot_kind;
  logic              use_after;

  assign slot_kind = head.kinds[idx];
  assign last_slot = (idx == head.cnt - 2'd1);
  // punctuation and string end sit after the consumed byte
  assign use_after = (slot_kind <= K_SEMI) || (slot_kind == K_STREND);
  assign load      = !empty && (!out_valid || !out_stall);
  assign pop       = load && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_slot ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= slot_kind;
      char_value    <= (slot_kind == K_IDCHAR || slot_kind == K_STRCHAR) ? head.ch : 8'd0;
      error_code    <= (slot_kind == K_ERROR) ? head.code : '0;
      line_number   <= use_after ? LINE_OUT_W'(head.line_a) : LINE_OUT_W'(head.line_b);
      column_number <= use_after ? COL_OUT_W'(head.col_a) : COL_OUT_W'(head.col_b);
      last          <= last_slot;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !empty |-> head.cnt != 2'd0)
    else $error("empty beat in queue");
  assert property (@(posedge clk) disable iff (rst) !empty |-> idx < head.cnt)
    else $error("slot index past result count");
  assert property (@(posedge clk) disable iff (rst) out_valid && kind == K_EOF |-> last)
    else $error("end of source not final result");

endmodule
